// ----- src/maze_wall_union_find_unit_assert.svh -----
// Assertion macros for the maze wall union-find unit.
// Each macro expects clk_i and rst_ni in scope at the place of use.
`ifndef MAZE_WALL_UNION_FIND_UNIT_ASSERT_SVH
`define MAZE_WALL_UNION_FIND_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define MWUF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWUF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MWUF_ASSERT_IMPL(lbl, ante, cons, msg)
`define MWUF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/mwuf_pkg.sv -----
package mwuf_pkg;

  localparam int FIELD_W     = 7;
  localparam int FIELD_RST   = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_WIDTH  = 1'b0,
    REG_FIELD_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_WALL  = 1'b1
  } cmd_e;

  // What the back end has to do with a queued item.
  typedef enum logic [1:0] {
    OP_START,
    OP_FIXED,
    OP_WALL
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_FIND_B
  } back_state_e;

  typedef struct packed {
    op_e  op;
    logic kept;
    logic oor;
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

  typedef struct packed {
    logic init_busy;
    logic pop;
  } back_status_t;

endpackage

// ----- src/mwuf_queue.sv -----
module mwuf_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int DEPTH = mwuf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign pop_data_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/mwuf_front.sv -----
module mwuf_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int CELL_W     = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mwuf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mwuf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [mwuf_pkg::FIELD_W-1:0]        wall_x_i,
  input  logic [mwuf_pkg::FIELD_W-1:0]        wall_y_i,
  input  logic                                vertical_i,
  input  mwuf_pkg::back_status_t              status_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output logic [mwuf_pkg::CTL_W+2*CELL_W-1:0] push_data_o
);

  localparam int FW = mwuf_pkg::FIELD_W;
  localparam logic [FW-1:0] WIDTH_RST =
    FW'((MAX_WIDTH < mwuf_pkg::FIELD_RST) ? MAX_WIDTH : mwuf_pkg::FIELD_RST);
  localparam logic [FW-1:0] HEIGHT_RST =
    FW'((MAX_HEIGHT < mwuf_pkg::FIELD_RST) ? MAX_HEIGHT : mwuf_pkg::FIELD_RST);

  logic [FW-1:0]       field_width_q, field_width_d;
  logic [FW-1:0]       field_height_q, field_height_d;
  logic [FW-1:0]       width_clamped, height_clamped;
  mwuf_pkg::item_ctl_t ctl;
  logic [CELL_W-1:0]   cell_a, cell_b;

  // Register writes: zero reads as one, anything above the maximum as the maximum.
  always_comb begin
    if (cfg_data_i == '0) begin
      width_clamped  = FW'(1);
      height_clamped = FW'(1);
    end else begin
      width_clamped  = (int'(cfg_data_i) > MAX_WIDTH) ? FW'(MAX_WIDTH) : cfg_data_i;
      height_clamped = (int'(cfg_data_i) > MAX_HEIGHT) ? FW'(MAX_HEIGHT) : cfg_data_i;
    end
    field_width_d  = field_width_q;
    field_height_d = field_height_q;
    if (cfg_we_i) begin
      case (mwuf_pkg::cfg_reg_e'(cfg_index_i))
        mwuf_pkg::REG_FIELD_WIDTH:  field_width_d  = width_clamped;
        mwuf_pkg::REG_FIELD_HEIGHT: field_height_d = height_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q  <= WIDTH_RST;
      field_height_q <= HEIGHT_RST;
    end else begin
      field_width_q  <= field_width_d;
      field_height_q <= field_height_d;
    end
  end

  // The lower or right cell sits at (x, y); the other one is above or to its left.
  always_comb begin
    cell_b = CELL_W'(wall_y_i) * CELL_W'(MAX_WIDTH) + CELL_W'(wall_x_i);
    cell_a = vertical_i ? (cell_b - CELL_W'(1)) : (cell_b - CELL_W'(MAX_WIDTH));
    ctl.op   = mwuf_pkg::OP_WALL;
    ctl.kept = 1'b0;
    ctl.oor  = 1'b0;
    if (mwuf_pkg::cmd_e'(cmd_i) == mwuf_pkg::CMD_START) begin
      ctl.op = mwuf_pkg::OP_START;
    end else if (!vertical_i) begin
      if (wall_x_i >= field_width_q || wall_y_i > field_height_q) begin
        ctl.op   = mwuf_pkg::OP_FIXED;
        ctl.kept = 1'b1;
        ctl.oor  = 1'b1;
      end else if (wall_y_i == '0 || wall_y_i == field_height_q) begin
        ctl.op   = mwuf_pkg::OP_FIXED;
        ctl.kept = 1'b1;
      end
    end else begin
      if (wall_x_i > field_width_q || wall_y_i >= field_height_q) begin
        ctl.op   = mwuf_pkg::OP_FIXED;
        ctl.kept = 1'b1;
        ctl.oor  = 1'b1;
      end else if (wall_x_i == '0 || wall_x_i == field_width_q) begin
        ctl.op   = mwuf_pkg::OP_FIXED;
        ctl.kept = 1'b1;
      end
    end
  end

  assign in_ready_o  = !q_full_i && !status_i.init_busy;
  assign push_o      = in_valid_i && in_ready_o;
  assign push_data_o = {ctl, cell_a, cell_b};

endmodule

// ----- src/mwuf_back.sv -----
module mwuf_back #(
  parameter int CELL_COUNT = 4096,
  parameter int CELL_W     = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  input  logic [mwuf_pkg::CTL_W+2*CELL_W-1:0] q_data_i,
  output mwuf_pkg::back_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                wall_kept_o,
  output logic                                out_of_range_o
);

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELL_COUNT - 1);

  mwuf_pkg::back_state_e state_q, state_d;
  mwuf_pkg::item_ctl_t   q_ctl;
  logic [CELL_W-1:0]     q_cell_a, q_cell_b;

  logic                  init_q, init_d;
  logic [CELL_W-1:0]     clr_q, clr_d;
  logic [CELL_W-1:0]     cur_q, cur_d;
  logic [CELL_W-1:0]     root_a_q, root_a_d;
  logic [CELL_W-1:0]     cell_b_q, cell_b_d;

  logic [CELL_W-1:0]     mem_q [CELL_COUNT];
  logic [CELL_W-1:0]     rd_data_q;
  logic                  rd_en;
  logic [CELL_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [CELL_W-1:0]     wr_addr, wr_data;

  logic                  pop;
  logic                  out_set, set_kept, set_oor;
  logic                  out_valid_q, out_kept_q, out_oor_q;

  assign {q_ctl, q_cell_a, q_cell_b} = q_data_i;

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    root_a_d = root_a_q;
    cell_b_d = cell_b_q;
    rd_en    = 1'b0;
    rd_addr  = cur_q;
    wr_en    = 1'b0;
    wr_addr  = clr_q;
    wr_data  = clr_q;
    pop      = 1'b0;
    out_set  = 1'b0;
    set_kept = 1'b0;
    set_oor  = 1'b0;
    case (state_q)
      mwuf_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_q == LAST_CELL) begin
          clr_d   = '0;
          state_d = mwuf_pkg::ST_IDLE;
          init_d  = 1'b0;
          out_set = !init_q;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      mwuf_pkg::ST_IDLE: begin
        if (!q_empty_i && !out_valid_q) begin
          pop = 1'b1;
          case (q_ctl.op)
            mwuf_pkg::OP_START: state_d = mwuf_pkg::ST_CLEAR;
            mwuf_pkg::OP_FIXED: begin
              out_set  = 1'b1;
              set_kept = q_ctl.kept;
              set_oor  = q_ctl.oor;
            end
            mwuf_pkg::OP_WALL: begin
              rd_en    = 1'b1;
              rd_addr  = q_cell_a;
              cur_d    = q_cell_a;
              cell_b_d = q_cell_b;
              state_d  = mwuf_pkg::ST_FIND_A;
            end
            default: ;
          endcase
        end
      end
      mwuf_pkg::ST_FIND_A: begin
        rd_en = 1'b1;
        if (rd_data_q == cur_q) begin
          root_a_d = cur_q;
          rd_addr  = cell_b_q;
          cur_d    = cell_b_q;
          state_d  = mwuf_pkg::ST_FIND_B;
        end else begin
          rd_addr = rd_data_q;
          cur_d   = rd_data_q;
        end
      end
      mwuf_pkg::ST_FIND_B: begin
        if (rd_data_q == cur_q) begin
          // Second root found: link it under the first unless they coincide.
          out_set  = 1'b1;
          set_kept = (cur_q == root_a_q);
          wr_en    = (cur_q != root_a_q);
          wr_addr  = cur_q;
          wr_data  = root_a_q;
          state_d  = mwuf_pkg::ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_data_q;
          cur_d   = rd_data_q;
        end
      end
      default: state_d = mwuf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwuf_pkg::ST_CLEAR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      clr_q   <= clr_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    root_a_q <= root_a_d;
    cell_b_q <= cell_b_d;
    if (out_set) begin
      out_kept_q <= set_kept;
      out_oor_q  <= set_oor;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign status_o.init_busy = init_q;
  assign status_o.pop       = pop;
  assign out_valid_o        = out_valid_q;
  assign wall_kept_o        = out_kept_q;
  assign out_of_range_o     = out_oor_q;

endmodule

// ----- src/maze_wall_union_find_unit.sv -----
// Kruskal maze engine: keeps one region link per cell of a grid of up to
// MAX_WIDTH x MAX_HEIGHT cells in a single memory and answers union-find queries
// on walls offered by the feeder, which also chooses the random wall order. After
// reset the block runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells (4096
// with the defaults) during which s_axis_tready is low; configuration writes are
// taken all the time. A start command is taken from the queue and runs a clearing
// pass over all cells in the back end, and then returns a beat with both flags
// clear. A border wall or one outside the field is answered without a memory
// access. An inner wall walks from each of the two cells to its region root: the
// memory has one read port and the walk follows one link per cycle. A finished
// result sits in an output register until it is taken, and the back end only
// takes its next item from the queue in the cycle after that. Items are
// classified as they are accepted and wait in a two-entry queue, so the feeder
// can push ahead while a walk or a start's clearing pass is still running.
`include "maze_wall_union_find_unit_assert.svh"

module maze_wall_union_find_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Register write port: index 0 is field_width, index 1 is field_height.
  input  logic                                cfg_we_i,
  input  logic [mwuf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mwuf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // From bit 0: wall_x[6:0], wall_y[13:7], vertical[14], zero pad[15].
  input  logic [mwuf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Bit 0: command (0 start a new maze, 1 offer a wall).
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // From bit 0: wall_kept[0], out_of_range[1], zero pad[7:2].
  output logic [mwuf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int ENTRY_W    = mwuf_pkg::CTL_W + 2 * CELL_W;
  localparam int FW         = mwuf_pkg::FIELD_W;

  mwuf_pkg::back_status_t status;
  logic                   q_push, q_empty, q_full;
  logic [ENTRY_W-1:0]     q_push_data, q_pop_data;
  logic                   wall_kept, out_of_range;

  // The front end classifies each beat against the field size as it is accepted:
  // start, a wall with a fixed answer (border or out of range), or an inner wall
  // with the memory indices of the two cells it separates.
  mwuf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CELL_W     (CELL_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .wall_x_i    (s_axis_tdata[FW-1:0]),
    .wall_y_i    (s_axis_tdata[2*FW-1:FW]),
    .vertical_i  (s_axis_tdata[2*FW]),
    .status_i    (status),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  mwuf_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (status.pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // The back end owns the link memory: clearing passes, both root walks and the
  // merge write all go through it, one item at a time.
  mwuf_back #(
    .CELL_COUNT (CELL_COUNT),
    .CELL_W     (CELL_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_pop_data),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .wall_kept_o    (wall_kept),
    .out_of_range_o (out_of_range)
  );

  assign m_axis_tdata = {{(mwuf_pkg::OUT_DATA_W - 2){1'b0}}, out_of_range, wall_kept};

  // No beat may enter while the memory is still being cleared after reset.
  `MWUF_ASSERT_IMPL(a_no_accept_in_init, status.init_busy, !s_axis_tready,
                    "input beat offered acceptance during the initial clearing pass")

  // The back end may only take an item that the queue actually holds.
  `MWUF_ASSERT_IMPL(a_pop_not_empty, status.pop, !q_empty,
                    "back end popped an empty queue")

  // A wall outside the field is never reported as removed.
  `MWUF_ASSERT_IMPL(a_oor_kept, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0],
                    "out-of-range wall reported as removed")

  // Once the initial clearing pass is over it never starts again.
  `MWUF_ASSERT_NEXT(a_init_once, !status.init_busy, !status.init_busy,
                    "initial clearing state re-entered without reset")

endmodule

// ----- tb/maze_wall_union_find_unit_test.sv -----
`timescale 1ns / 100ps

module maze_wall_union_find_unit_test;

  // The block is built with its default grid of 64 x 64 cells.
  localparam int GRID_MAX      = 64;
  localparam int CELL_COUNT    = GRID_MAX * GRID_MAX;
  // Number of items offered by the random maze phase.
  localparam int RANDOM_ITEMS  = 1150;
  // Large fields are only partly walked, so that the find walks stay short.
  localparam int MAZE_WALL_CAP = 160;
  // Length in cycles of the long output hold-off.
  localparam int LONG_HOLD     = 300;

  // One wall segment as the feeder names it: left/top corner and orientation.
  typedef struct packed {
    logic [6:0] x;
    logic [6:0] y;
    logic       vertical;
  } wall_t;

  // The two result flags; wall_kept is the lowest bit, as on m_axis_tdata.
  typedef struct packed {
    logic out_of_range;
    logic wall_kept;
  } wall_verdict_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [mwuf_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [mwuf_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // From bit 0: wall_x[6:0], wall_y[13:7], vertical[14], zero pad[15].
  logic [mwuf_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // Bit 0: command (0 start a new maze, 1 offer a wall).
  logic                            s_axis_tuser  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // From bit 0: wall_kept[0], out_of_range[1], zero pad[7:2].
  logic [mwuf_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  maze_wall_union_find_unit #(
    .MAX_WIDTH  (GRID_MAX),
    .MAX_HEIGHT (GRID_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Our own copy of the region links and of the field size.
  logic [11:0]   region_link [CELL_COUNT];
  int unsigned   field_cols;
  int unsigned   field_rows;

  // Verdicts still owed by the block, oldest first.
  wall_verdict_t verdict_q[$];
  // Inner walls of the current field in the order they will be offered.
  wall_t         maze_walls[$];

  int unsigned   items_sent        = 0;
  int unsigned   mismatch_count    = 0;
  // Random idling on both sides is switched off for the final stretch.
  bit            idle_enable       = 1'b1;
  // A non-zero value asks the result sink for a hold-off of that many cycles.
  int unsigned   hold_off_request  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Every cell becomes its own region again.
  function automatic void clear_regions();
    int i;
    for (i = 0; i < CELL_COUNT; i++) region_link[i] = 12'(i);
  endfunction

  // Follows the links up to the region root; the walk is bounded by the cell
  // count, which the hardware walk is not.
  function automatic logic [11:0] region_root(logic [11:0] node);
    int unsigned steps;
    steps = 0;
    while (steps < CELL_COUNT && region_link[node] != node) begin
      node = region_link[node];
      steps++;
    end
    return node;
  endfunction

  // A written size of zero is held as one, anything above the grid as the grid.
  function automatic int unsigned clamp_size(logic [6:0] raw);
    if (raw == 7'd0) return 1;
    if (raw > GRID_MAX) return GRID_MAX;
    return int'(raw);
  endfunction

  // Works out the verdict for one accepted beat and updates the links.
  function automatic wall_verdict_t predict_verdict(mwuf_pkg::cmd_e cmd, wall_t w);
    wall_verdict_t v;
    int unsigned   ax, ay, bx, by;
    logic [11:0]   ra, rb;
    v.out_of_range = 1'b0;
    v.wall_kept    = 1'b1;
    if (cmd == mwuf_pkg::CMD_START) begin
      clear_regions();
      v.wall_kept = 1'b0;
      return v;
    end
    if (!w.vertical) begin
      // A horizontal wall lies between rows y-1 and y.
      if (w.x >= field_cols || w.y > field_rows) begin
        v.out_of_range = 1'b1;
        return v;
      end
      if (w.y == 0 || w.y == field_rows) return v;
      ax = w.x;
      ay = w.y - 1;
      bx = w.x;
      by = w.y;
    end else begin
      // A vertical wall lies between columns x-1 and x.
      if (w.x > field_cols || w.y >= field_rows) begin
        v.out_of_range = 1'b1;
        return v;
      end
      if (w.x == 0 || w.x == field_cols) return v;
      ax = w.x - 1;
      ay = w.y;
      bx = w.x;
      by = w.y;
    end
    ra = region_root(12'(ay * GRID_MAX + ax));
    rb = region_root(12'(by * GRID_MAX + bx));
    // The root of the second cell is hung below the root of the first.
    if (ra != rb) begin
      region_link[rb] = ra;
      v.wall_kept = 1'b0;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic wall_t make_wall(int unsigned x, int unsigned y, bit vertical);
    wall_t w;
    w.x        = 7'(x);
    w.y        = 7'(y);
    w.vertical = vertical;
    return w;
  endfunction

  // Any corner in the whole 7-bit range, mostly outside the field.
  function automatic wall_t random_wall();
    return make_wall($urandom_range(0, 127), $urandom_range(0, 127),
                     1'($urandom_range(0, 1)));
  endfunction

  // A wall on the border of the field or just beyond it.
  function automatic wall_t near_border_wall();
    wall_t w;
    w.vertical = 1'($urandom_range(0, 1));
    if (w.vertical) begin
      case ($urandom_range(0, 2))
        0:       w.x = 7'd0;
        1:       w.x = 7'(field_cols);
        default: w.x = 7'(field_cols + 1);
      endcase
      w.y = 7'($urandom_range(0, field_rows));
    end else begin
      case ($urandom_range(0, 2))
        0:       w.y = 7'd0;
        1:       w.y = 7'(field_rows);
        default: w.y = 7'(field_rows + 1);
      endcase
      w.x = 7'($urandom_range(0, field_cols));
    end
    return w;
  endfunction

  // Mostly small fields, now and then a raw value that the block must clamp.
  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd64;
      3:       return 7'($urandom_range(65, 126));
      default: return 7'($urandom_range(2, 10));
    endcase
  endfunction

  // Lists every inner wall of the current field and shuffles the list, which
  // is the wall order that a Kruskal feeder would use.
  task automatic build_maze_walls();
    int unsigned x, y, i, j;
    wall_t       swap;
    maze_walls.delete();
    for (y = 1; y < field_rows; y++)
      for (x = 0; x < field_cols; x++)
        maze_walls.insert(maze_walls.size(), make_wall(x, y, 1'b0));
    for (y = 0; y < field_rows; y++)
      for (x = 1; x < field_cols; x++)
        maze_walls.insert(maze_walls.size(), make_wall(x, y, 1'b1));
    for (i = maze_walls.size(); i > 1; i--) begin
      j = $urandom_range(0, i - 1);
      swap = maze_walls[i - 1];
      maze_walls[i - 1] = maze_walls[j];
      maze_walls[j] = swap;
    end
  endtask

  // Offers one beat and waits for it to be taken. The valid is left high on
  // return, so that the next beat can follow on the very next cycle.
  task automatic send_beat(mwuf_pkg::cmd_e cmd, wall_t w);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, w.vertical, w.y, w.x};
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q.insert(verdict_q.size(), predict_verdict(cmd, w));
    items_sent++;
  endtask

  // Stops offering and waits until every owed verdict has arrived, then waits
  // on so that the block settles before a register is written.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_field(mwuf_pkg::cfg_reg_e which, logic [6:0] raw);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= raw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (which == mwuf_pkg::REG_FIELD_WIDTH) field_cols = clamp_size(raw);
    else field_rows = clamp_size(raw);
    @(posedge clk_i);
  endtask

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------

  // Drives m_axis_tready: short random stalls while idling is on, and a long
  // hold-off, counted here cycle by cycle, whenever a test asks for one.
  initial begin : result_sink
    int unsigned held, hold_len, stall;
    forever begin
      @(posedge clk_i);
      if (hold_off_request != 0) begin
        hold_len = hold_off_request;
        hold_off_request = 0;
        m_axis_tready <= 1'b0;
        for (held = 0; held < hold_len; held++) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  wall_verdict_t seen_verdict;
  wall_verdict_t want_verdict;

  // Each result beat is held against the oldest owed verdict.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_verdict = m_axis_tdata[1:0];
      if (verdict_q.size() == 0) begin
        note_mismatch($sformatf("result beat with none owed: wall_kept=%0b out_of_range=%0b",
                                seen_verdict.wall_kept, seen_verdict.out_of_range));
      end else begin
        want_verdict = verdict_q.pop_front();
        if (seen_verdict.wall_kept !== want_verdict.wall_kept ||
            seen_verdict.out_of_range !== want_verdict.out_of_range)
          note_mismatch($sformatf(
              "wall_kept expected %0b got %0b, out_of_range expected %0b got %0b",
              want_verdict.wall_kept, seen_verdict.wall_kept,
              want_verdict.out_of_range, seen_verdict.out_of_range));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset size of 16 x 16: border walls, walls outside the field, merges, a
  // closed loop of four cells, the far corner, and a start that undoes merges.
  task automatic test_default_field();
    send_beat(mwuf_pkg::CMD_START, random_wall());
    send_beat(mwuf_pkg::CMD_WALL, make_wall(3, 0, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(3, 16, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 5, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(16, 5, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(16, 2, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(2, 17, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(17, 2, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(2, 16, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(127, 127, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(127, 127, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 1, 1'b0));
    // The same wall again now joins cells of one region and is kept.
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 1, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(1, 0, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(1, 1, 1'b0));
    // The fourth side of the two-by-two square would close a loop.
    send_beat(mwuf_pkg::CMD_WALL, make_wall(1, 1, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(15, 15, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(15, 15, 1'b0));
    send_beat(mwuf_pkg::CMD_START, random_wall());
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 1, 1'b0));
    wait_results_drained();
  endtask

  // Size registers at and beyond their limits, written without a start so
  // that the links of the earlier maze are carried over.
  task automatic test_field_limits();
    write_field(mwuf_pkg::REG_FIELD_WIDTH, 7'd0);
    write_field(mwuf_pkg::REG_FIELD_HEIGHT, 7'd127);
    send_beat(mwuf_pkg::CMD_WALL, make_wall(1, 5, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 63, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 64, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 65, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(1, 3, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 64, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(0, 63, 1'b0));
    wait_results_drained();
    write_field(mwuf_pkg::REG_FIELD_WIDTH, 7'd64);
    write_field(mwuf_pkg::REG_FIELD_HEIGHT, 7'd0);
    send_beat(mwuf_pkg::CMD_WALL, make_wall(63, 0, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(64, 0, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(65, 0, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(63, 1, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(64, 1, 1'b0));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(5, 2, 1'b0));
    wait_results_drained();
    write_field(mwuf_pkg::REG_FIELD_WIDTH, 7'd100);
    write_field(mwuf_pkg::REG_FIELD_HEIGHT, 7'd64);
    send_beat(mwuf_pkg::CMD_WALL, make_wall(63, 63, 1'b1));
    send_beat(mwuf_pkg::CMD_WALL, make_wall(63, 63, 1'b0));
    wait_results_drained();
  endtask

  // The sink holds off for a long stretch while walls keep coming, so the
  // queue and the output register fill and the input has to stall.
  task automatic test_output_backpressure();
    int unsigned i;
    write_field(mwuf_pkg::REG_FIELD_WIDTH, 7'd8);
    write_field(mwuf_pkg::REG_FIELD_HEIGHT, 7'd8);
    build_maze_walls();
    send_beat(mwuf_pkg::CMD_START, random_wall());
    hold_off_request = LONG_HOLD;
    for (i = 0; i < 16; i++) send_beat(mwuf_pkg::CMD_WALL, maze_walls[i]);
    wait_results_drained();
  endtask

  // Shuffled wall lists of random fields, with some noise mixed in: walls
  // outside or on the border, repeats, the odd start mid-maze, mazes left
  // unfinished, and now and then a resize part way through a maze.
  task automatic test_random_mazes();
    int unsigned goal, pos, budget, pick, resize_at;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      wait_results_drained();
      write_field(mwuf_pkg::REG_FIELD_WIDTH, pick_size());
      write_field(mwuf_pkg::REG_FIELD_HEIGHT, pick_size());
      build_maze_walls();
      budget = (maze_walls.size() < MAZE_WALL_CAP) ? maze_walls.size() : MAZE_WALL_CAP;
      if ($urandom_range(0, 11) == 0) budget = $urandom_range(0, budget);
      resize_at = ($urandom_range(0, 9) == 0) ? budget / 2 : budget + 1;
      send_beat(mwuf_pkg::CMD_START, random_wall());
      pos = 0;
      while (pos < budget && items_sent < goal) begin
        if (pos == resize_at) begin
          wait_results_drained();
          write_field($urandom_range(0, 1) ? mwuf_pkg::REG_FIELD_HEIGHT
                                           : mwuf_pkg::REG_FIELD_WIDTH, pick_size());
          resize_at = budget + 1;
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          send_beat(mwuf_pkg::CMD_WALL, random_wall());
        end else if (pick == 1) begin
          send_beat(mwuf_pkg::CMD_WALL, near_border_wall());
        end else if (pick == 2 && pos > 0) begin
          send_beat(mwuf_pkg::CMD_WALL, maze_walls[$urandom_range(0, pos - 1)]);
        end else if (pick == 3 && $urandom_range(0, 15) == 0) begin
          send_beat(mwuf_pkg::CMD_START, random_wall());
        end else begin
          send_beat(mwuf_pkg::CMD_WALL, maze_walls[pos]);
          pos++;
        end
      end
    end
    wait_results_drained();
  endtask

  // A whole maze back to back, with no idling on either side.
  task automatic test_final_stretch();
    int unsigned i;
    idle_enable = 1'b0;
    write_field(mwuf_pkg::REG_FIELD_WIDTH, 7'd6);
    write_field(mwuf_pkg::REG_FIELD_HEIGHT, 7'd6);
    build_maze_walls();
    send_beat(mwuf_pkg::CMD_START, random_wall());
    for (i = 0; i < maze_walls.size(); i++) send_beat(mwuf_pkg::CMD_WALL, maze_walls[i]);
    wait_results_drained();
  endtask

  initial begin : test_sequence
    field_cols = mwuf_pkg::FIELD_RST;
    field_rows = mwuf_pkg::FIELD_RST;
    clear_regions();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The clearing pass after reset shows up as a long low tready, which the
    // first beat simply waits out.
    test_default_field();
    test_field_limits();
    test_output_backpressure();
    test_random_mazes();
    test_final_stretch();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run: all the clearing passes over the 4096
  // cells, plus every beat walking long chains under the worst stalls.
  initial begin : run_limit
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
